// File: design/assert_macros.svh
// Assertion helpers for the RTL modules; included by the scan unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_ALWAYS(lbl, clk, rst, !(expr), msg)

`endif

// File: design/lisc_pkg.sv
package lisc_pkg;

   // Default storage depth in elements.
   localparam int MAX_ITEMS_DEF = 1024;

   // Fixed widths of the transaction fields.
   localparam int VALUE_W   = 32;
   localparam int LEN_OUT_W = 11;
   localparam int IDX_OUT_W = 10;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [LEN_OUT_W-1:0]      len_out_type;
   typedef logic [IDX_OUT_W-1:0]      idx_out_type;

   // One finished result as handed from the scan unit to the output register.
   typedef struct packed {
      len_out_type length_here;
      len_out_type best_length;
      idx_out_type best_end;
      logic        overflow;
      logic        last;
   } result_type;

   // Handoff control between the scan unit and the output register.
   typedef struct packed {
      logic valid;
   } res_ctl_type;

   typedef struct packed {
      logic free;
   } out_ctl_type;

endpackage

// File: design/lisc_store.sv
module lisc_store #(
   parameter int MAX_ITEMS = lisc_pkg::MAX_ITEMS_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_ITEMS)-1:0]    wr_addr,
   input  lisc_pkg::value_type             wr_value,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]  wr_length,
   input  logic                            rd_en,
   input  logic [$clog2(MAX_ITEMS)-1:0]    rd_addr,
   output lisc_pkg::value_type             rd_value,
   output logic [$clog2(MAX_ITEMS+1)-1:0]  rd_length
);

   localparam int LEN_W = $clog2(MAX_ITEMS+1);

   lisc_pkg::value_type value_mem [MAX_ITEMS];
   logic [LEN_W-1:0]    length_mem [MAX_ITEMS];

   lisc_pkg::value_type rd_value_ff;
   logic [LEN_W-1:0]    rd_length_ff;

   // Single write port for both stores.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr]  <= wr_value;
         length_mem[wr_addr] <= wr_length;
      end
   end

   // Single read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff  <= value_mem[rd_addr];
         rd_length_ff <= length_mem[rd_addr];
      end
   end

   assign rd_value  = rd_value_ff;
   assign rd_length = rd_length_ff;

endmodule

// File: design/lisc_scan.sv
`include "assert_macros.svh"

module lisc_scan #(
   parameter int MAX_ITEMS = lisc_pkg::MAX_ITEMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lisc_pkg::value_type             req_value,
   input  logic                            req_last,
   output logic                            rd_en,
   output logic [$clog2(MAX_ITEMS)-1:0]    rd_addr,
   input  lisc_pkg::value_type             rd_value,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]  rd_length,
   output logic                            wr_en,
   output logic [$clog2(MAX_ITEMS)-1:0]    wr_addr,
   output lisc_pkg::value_type             wr_value,
   output logic [$clog2(MAX_ITEMS+1)-1:0]  wr_length,
   input  lisc_pkg::out_ctl_type           out_ctl,
   output lisc_pkg::res_ctl_type           res_ctl,
   output lisc_pkg::result_type            res
);

   localparam int LEN_W = $clog2(MAX_ITEMS+1);
   localparam int IDX_W = $clog2(MAX_ITEMS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } scan_state_type;

   scan_state_type      state_ff, state_in;
   logic [LEN_W-1:0]    count_ff, count_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [LEN_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                pend_ff, pend_in;
   logic [LEN_W-1:0]    here_ff, here_in;
   lisc_pkg::value_type value_ff, value_in;
   logic                last_ff, last_in;
   logic                drop_ff, drop_in;

   logic [LEN_W-1:0]    best_len_new;
   logic [IDX_W-1:0]    best_idx_new;
   logic [LEN_W-1:0]    cand_len;

   assign req_stall = (state_ff != ST_IDLE);
   assign rd_addr   = rd_idx_ff[IDX_W-1:0];
   assign wr_addr   = count_ff[IDX_W-1:0];
   assign wr_value  = value_ff;
   assign wr_length = here_ff;
   assign cand_len  = rd_length + LEN_W'(1);

   // Best length and its index after this element, before any end-of-sequence clear.
   always_comb begin
      best_len_new = best_len_ff;
      best_idx_new = best_idx_ff;
      if (!drop_ff && (here_ff > best_len_ff)) begin
         best_len_new = here_ff;
         best_idx_new = count_ff[IDX_W-1:0];
      end
   end

   // Sequencer: accept, scan stored entries one read per cycle, then commit.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      best_len_in = best_len_ff;
      best_idx_in = best_idx_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = pend_ff;
      here_in     = here_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      drop_in     = drop_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      res_ctl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in  = req_value;
               last_in   = req_last;
               drop_in   = (count_ff == LEN_W'(MAX_ITEMS));
               here_in   = LEN_W'(1);
               rd_idx_in = '0;
               pend_in   = 1'b0;
               state_in  = (count_ff == LEN_W'(MAX_ITEMS)) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in = 1'b0;
            if (rd_idx_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + LEN_W'(1);
               pend_in   = 1'b1;
            end
            // Fold in the entry whose read data arrived this cycle.
            if (pend_ff && (rd_value < value_ff) && (cand_len > here_ff)) begin
               here_in = cand_len;
            end
            if (!pend_ff && (rd_idx_ff == count_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_ctl.free) begin
               res_ctl.valid = 1'b1;
               state_in      = ST_IDLE;
               if (!drop_ff) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + LEN_W'(1);
               end
               best_len_in = best_len_new;
               best_idx_in = best_idx_new;
               if (last_ff) begin
                  count_in    = '0;
                  best_len_in = '0;
                  best_idx_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result of the current transaction.
   always_comb begin
      res.length_here = drop_ff ? '0 : lisc_pkg::len_out_type'(here_ff);
      res.best_length = lisc_pkg::len_out_type'(best_len_new);
      res.best_end    = lisc_pkg::idx_out_type'(best_idx_new);
      res.overflow    = drop_ff;
      res.last        = last_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         best_len_ff <= '0;
         best_idx_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         best_len_ff <= best_len_in;
         best_idx_ff <= best_idx_in;
         pend_ff     <= pend_in;
      end
   end

   // Working registers of the transaction in flight.
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      here_ff   <= here_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
      drop_ff   <= drop_in;
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= LEN_W'(MAX_ITEMS), "Element count exceeds capacity.")
   `ASSERT_ALWAYS(a_best_bound, clock, reset, best_len_ff <= count_ff, "Best length exceeds element count.")
   `ASSERT_NEVER(a_read_range, clock, reset, rd_en && (rd_idx_ff >= count_ff), "Read beyond stored elements.")
   `ASSERT_ALWAYS(a_last_clears, clock, reset, (res_ctl.valid && last_ff) |=> (count_ff == '0 && best_len_ff == '0), "Sequence state not cleared after last.")

endmodule

// File: design/longest_increasing_subsequence_core.sv
// Streaming longest strictly increasing subsequence (quadratic dynamic program).
// Each transaction carries one signed value; the core compares it against every
// element stored so far in the current sequence, reading the value and length
// stores through one synchronous read port at one entry per cycle. A transaction
// passes through acceptance, one read per stored element, the arrival of the last
// read data, the close of the scan and a commit; with an empty store the scan ends
// without reads, and an element dropped for lack of storage goes from acceptance
// straight to its commit. The result waits in an output register, so the next
// transaction is accepted while an earlier result is still stalled; the commit
// waits only while that register is full and its receiver stalls.
// A set last flag ends the sequence; elements beyond MAX_ITEMS are dropped and
// flagged with overflow.
module longest_increasing_subsequence_core #(
   parameter int MAX_ITEMS = lisc_pkg::MAX_ITEMS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lisc_pkg::value_type   req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lisc_pkg::len_out_type rsp_length_here,
   output lisc_pkg::len_out_type rsp_best_length,
   output lisc_pkg::idx_out_type rsp_best_end,
   output logic                  rsp_overflow,
   output logic                  rsp_last_out
);

   localparam int LEN_W = $clog2(MAX_ITEMS+1);
   localparam int IDX_W = $clog2(MAX_ITEMS);

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   lisc_pkg::value_type   rd_value;
   logic [LEN_W-1:0]      rd_length;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   lisc_pkg::value_type   wr_value;
   logic [LEN_W-1:0]      wr_length;
   lisc_pkg::out_ctl_type out_ctl;
   lisc_pkg::res_ctl_type res_ctl;
   lisc_pkg::result_type  res;

   logic                  rsp_valid_ff, rsp_valid_in;
   lisc_pkg::result_type  rsp_data_ff;

   lisc_store #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_value  (wr_value),
      .wr_length (wr_length),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_value  (rd_value),
      .rd_length (rd_length)
   );

   lisc_scan #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .req_last  (req_last),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_value  (rd_value),
      .rd_length (rd_length),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_value  (wr_value),
      .wr_length (wr_length),
      .out_ctl   (out_ctl),
      .res_ctl   (res_ctl),
      .res       (res)
   );

   // The output register can take a result when empty or when being drained.
   assign out_ctl.free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_ctl.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ctl.valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_length_here = rsp_data_ff.length_here;
   assign rsp_best_length = rsp_data_ff.best_length;
   assign rsp_best_end    = rsp_data_ff.best_end;
   assign rsp_overflow    = rsp_data_ff.overflow;
   assign rsp_last_out    = rsp_data_ff.last;

endmodule

// File: bench/longest_increasing_subsequence_core_tb.sv
`timescale 1ns / 100ps

module longest_increasing_subsequence_core_tb;

   localparam int STORE_DEPTH = lisc_pkg::MAX_ITEMS_DEF;
   localparam lisc_pkg::value_type VALUE_MIN = 32'sh8000_0000;
   localparam lisc_pkg::value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_PHASE_ITEMS = 145;

   // Flavors of random sequence content.
   typedef enum int {
      VALS_WIDE,
      VALS_NARROW,
      VALS_RISING,
      VALS_CORNER
   } value_mix_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   lisc_pkg::value_type   req_value;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_stall;
   lisc_pkg::len_out_type rsp_length_here;
   lisc_pkg::len_out_type rsp_best_length;
   lisc_pkg::idx_out_type rsp_best_end;
   logic                  rsp_overflow;
   logic                  rsp_last_out;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   int idle_pct;
   int stall_pct;
   int mismatch_count;

   // Results predicted for accepted transactions, oldest first.
   lisc_pkg::result_type lis_results_due[$];

   // Predictor copy of the sequence held in the core.
   lisc_pkg::value_type held_values [STORE_DEPTH];
   int                  held_lengths[STORE_DEPTH];
   int                  held_count;
   int                  best_len;
   int                  best_idx;

   longest_increasing_subsequence_core #(
      .MAX_ITEMS(STORE_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_length_here(rsp_length_here),
      .rsp_best_length(rsp_best_length),
      .rsp_best_end   (rsp_best_end),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_out   (rsp_last_out)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the LIS result of one element and advance the held sequence.
   function automatic lisc_pkg::result_type extend_lis(lisc_pkg::value_type value,
                                                       logic last);
      lisc_pkg::result_type res;
      int here;
      res  = '0;
      here = 0;
      if (held_count < STORE_DEPTH) begin
         here = 1;
         for (int i = 0; i < held_count; i++) begin
            if (held_values[i] < value && held_lengths[i] + 1 > here) begin
               here = held_lengths[i] + 1;
            end
         end
         held_values[held_count]  = value;
         held_lengths[held_count] = here;
         // Only a strictly longer run moves the end index, so ties keep the first.
         if (here > best_len) begin
            best_len = here;
            best_idx = held_count;
         end
         held_count++;
      end else begin
         res.overflow = 1'b1;
      end
      res.length_here = lisc_pkg::len_out_type'(here);
      res.best_length = lisc_pkg::len_out_type'(best_len);
      res.best_end    = lisc_pkg::idx_out_type'(best_idx);
      res.last        = last;
      // The final element closes the sequence after its result is formed.
      if (last) begin
         held_count = 0;
         best_len   = 0;
         best_idx   = 0;
      end
      return res;
   endfunction

   // Draw one element value of the given flavor.
   function automatic lisc_pkg::value_type pick_value(value_mix_type mix,
                                                      lisc_pkg::value_type prev);
      lisc_pkg::value_type v;
      case (mix)
         VALS_WIDE: begin
            v = $urandom;
         end
         VALS_NARROW: begin
            v = lisc_pkg::value_type'(int'($urandom_range(0, 15)) - 8);
         end
         VALS_RISING: begin
            v = prev + lisc_pkg::value_type'(int'($urandom_range(0, 1000)) - 200);
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       v = VALUE_MIN;
               1:       v = VALUE_MAX;
               2:       v = '0;
               3:       v = '1;
               default: v = $urandom;
            endcase
         end
      endcase
      return v;
   endfunction

   // Offer one element and hold it until the core takes the transaction.
   task automatic send_element(lisc_pkg::value_type value, logic last);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         req_last  <= $urandom_range(0, 1);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do begin
         @(posedge clock);
      end while (req_stall);
      lis_results_due.push_back(extend_lis(value, last));
      @(negedge clock);
   endtask

   // Send a whole sequence, marking its final element.
   task automatic send_sequence(lisc_pkg::value_type values[$]);
      foreach (values[i]) begin
         send_element(values[i], i == values.size() - 1);
      end
   endtask

   // Stop offering work and wait until every predicted result has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (lis_results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (STORE_DEPTH + 8) @(negedge clock);
   endtask

   // Single element, signed extremes and sign boundaries.
   task automatic test_signed_extremes();
      lisc_pkg::value_type seq[$];
      idle_pct  = 0;
      stall_pct = 0;
      seq = {32'sd0};
      send_sequence(seq);
      seq = {VALUE_MIN, VALUE_MAX, 32'sd0, -32'sd1, 32'sd1, VALUE_MAX - 1, VALUE_MAX};
      send_sequence(seq);
   endtask

   // Equal values, ties on the best length, and a falling sequence.
   task automatic test_ties_and_falling();
      lisc_pkg::value_type seq[$];
      seq = {32'sd10, 32'sd20, 32'sd15, 32'sd17, 32'sd30, 32'sd25};
      send_sequence(seq);
      seq = {32'sd5, 32'sd5, 32'sd5, 32'sd3, 32'sd4};
      send_sequence(seq);
      seq = {VALUE_MAX, 32'sd100, 32'sd0, -32'sd100, VALUE_MIN};
      send_sequence(seq);
   endtask

   // Fill the store with a rising run, overflow it, end on a dropped element.
   task automatic test_storage_full();
      lisc_pkg::value_type v;
      lisc_pkg::value_type seq[$];
      idle_pct  = 0;
      stall_pct = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         v = VALUE_MIN + lisc_pkg::value_type'(i * 4096 + int'($urandom_range(0, 4095)));
         send_element(v, 1'b0);
      end
      send_element($urandom, 1'b0);
      send_element(VALUE_MAX, 1'b1);
      // The next sequence must start from a cleared count.
      seq = {-32'sd5, 32'sd7};
      send_sequence(seq);
   endtask

   // Random sequences of mixed length and content under one setting of sender idling and receiver stalls.
   task automatic test_random_sequences(int sender_idle, int receiver_stall, int items);
      int                  sent;
      int                  seq_len;
      value_mix_type       mix;
      lisc_pkg::value_type prev;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      sent      = 0;
      while (sent < items) begin
         case ($urandom_range(0, 19))
            0:          seq_len = $urandom_range(121, 300);
            1, 2, 3:    seq_len = $urandom_range(25, 120);
            default:    seq_len = $urandom_range(1, 24);
         endcase
         mix  = value_mix_type'($urandom_range(0, 3));
         prev = $urandom;
         for (int i = 0; i < seq_len; i++) begin
            prev = pick_value(mix, prev);
            send_element(prev, i == seq_len - 1);
         end
         sent += seq_len;
      end
   endtask

   // Receiver back-pressure, changed at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      lisc_pkg::result_type seen;
      lisc_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.length_here = rsp_length_here;
         seen.best_length = rsp_best_length;
         seen.best_end    = rsp_best_end;
         seen.overflow    = rsp_overflow;
         seen.last        = rsp_last_out;
         if (lis_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: unexpected result len=%0d best=%0d end=%0d ovf=%0b last=%0b",
                        $realtime, seen.length_here, seen.best_length, seen.best_end,
                        seen.overflow, seen.last);
            end
         end else begin
            want = lis_results_due.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: expected len=%0d best=%0d end=%0d ovf=%0b last=%0b",
                           $realtime, want.length_here, want.best_length, want.best_end,
                           want.overflow, want.last);
                  $display("%0t: actual   len=%0d best=%0d end=%0d ovf=%0b last=%0b",
                           $realtime, seen.length_here, seen.best_length, seen.best_end,
                           seen.overflow, seen.last);
               end
            end
         end
      end
   end

   // Main sequence of tests.
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      req_last       = 1'b0;
      rsp_stall      = 1'b0;
      idle_pct       = 0;
      stall_pct      = 0;
      mismatch_count = 0;
      held_count     = 0;
      best_len       = 0;
      best_idx       = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_signed_extremes();
      test_ties_and_falling();
      test_storage_full();
      test_random_sequences(0, 0, RANDOM_PHASE_ITEMS);
      test_random_sequences(49, 0, RANDOM_PHASE_ITEMS);
      test_random_sequences(0, 49, RANDOM_PHASE_ITEMS);
      test_random_sequences(27, 27, RANDOM_PHASE_ITEMS);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: longest_increasing_subsequence_core.f
+incdir+design
design/lisc_pkg.sv
design/lisc_store.sv
design/lisc_scan.sv
design/longest_increasing_subsequence_core.sv
bench/longest_increasing_subsequence_core_tb.sv
